@@ rtl/wsa_pkg.sv @@
// Shared constants for the windowed sample average block.
// Parameter defaults and fixed field widths; no dependencies.
package wsa_pkg;

  localparam int WINDOW_CAPACITY_DEF = 16;
  localparam int SAMPLE_WIDTH_DEF    = 16;

  // Count fields and the window length register are five bits wide.
  localparam int COUNT_W             = 5;
  localparam logic [COUNT_W-1:0] WINDOW_RESET_LENGTH = 5'd10;

  // Register byte address bit that selects the register index.
  localparam logic ADDR_WINDOW_LENGTH = 1'b0;

endpackage

@@ rtl/windowed_sample_average_top.sv @@
// Windowed sample average: ring store, running sums and a shared divider.
// Depends on wsa_pkg for parameter defaults and field widths.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready/s_tdata, each one sample of
//   (pos_x, pos_y, sample_speed). Every accepted word produces one output
//   word on m_tvalid/m_tready/m_tdata with the count of samples held and the
//   three averages over the window, each truncated toward zero.
//   The window length register (byte address 0 on the APB port) selects how
//   many recent samples are averaged; writing it empties the window. A length
//   of zero acts as one, and a length above the capacity acts as the capacity.
//   Each word passes through a store read and the sum update, then for each
//   of the three averages a load and SAMPLE_WIDTH+5 steps of the radix-2
//   restoring divider, then a completion state. Only one word is processed
//   at a time; a new word is accepted only after the prior result is registered.
//   The result register frees the processing path: if the receiver stalls,
//   the finished word waits in m_tdata and the block still accepts one more
//   word, then holds that word's result until the register empties.
//   Reset empties the window and sets the length to 10; the store itself is
//   not cleared, since an entry is only read back after it has been written.
module windowed_sample_average_top #(
  parameter int WINDOW_CAPACITY = wsa_pkg::WINDOW_CAPACITY_DEF,
  parameter int SAMPLE_WIDTH    = wsa_pkg::SAMPLE_WIDTH_DEF,
  localparam int IN_W  = ((3 * SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_W = ((3 * SAMPLE_WIDTH + wsa_pkg::COUNT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // Fields from bit 0 up: pos_x, pos_y, sample_speed.
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // Fields from bit 0 up: sample_count, avg_x, avg_y, avg_speed, zero fill.
  output logic [OUT_W-1:0] m_tdata,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int SW      = SAMPLE_WIDTH;
  localparam int CW      = wsa_pkg::COUNT_W;
  localparam int SUM_W   = SW + CW;
  localparam int REM_W   = CW + 1;
  localparam int SLOT_W  = $clog2(WINDOW_CAPACITY);
  localparam int LW      = (SLOT_W + 1 > CW) ? SLOT_W + 1 : CW;
  localparam int STEP_W  = $clog2(SUM_W);
  localparam int ENTRY_W = 3 * SW;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_LOAD = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  localparam logic [1:0] COMP_X     = 2'd0;
  localparam logic [1:0] COMP_Y     = 2'd1;
  localparam logic [1:0] COMP_SPEED = 2'd2;

  logic [2:0]               state;
  logic [CW-1:0]            window_length;
  logic [SLOT_W-1:0]        write_slot;
  logic [CW-1:0]            fill_count;
  logic signed [SUM_W-1:0]  sum_x;
  logic signed [SUM_W-1:0]  sum_y;
  logic signed [SUM_W-1:0]  sum_speed;
  logic [1:0]               comp;
  logic [STEP_W-1:0]        step;

  logic signed [SW-1:0]     in_x;
  logic signed [SW-1:0]     in_y;
  logic signed [SW-1:0]     in_s;
  logic [SLOT_W-1:0]        cur_slot;
  logic [ENTRY_W-1:0]       rd_data;
  logic [ENTRY_W-1:0]       store [WINDOW_CAPACITY];
  logic [REM_W-1:0]         div_rem;
  logic [SUM_W-1:0]         div_quo;
  logic                     div_neg;
  logic [SW-1:0]            avg_x;
  logic [SW-1:0]            avg_y;
  logic [SW-1:0]            avg_s;
  logic [CW-1:0]            out_count;
  logic [SW-1:0]            out_x;
  logic [SW-1:0]            out_y;
  logic [SW-1:0]            out_s;

  logic [LW-1:0]            eff_len;
  logic [LW-1:0]            wl_ext;
  logic [LW-1:0]            slot_inc;
  logic [SLOT_W-1:0]        slot_wrap_next;
  logic [SLOT_W-1:0]        start_slot;
  logic                     window_full;
  logic                     cfg_we;
  logic signed [SW-1:0]     old_x;
  logic signed [SW-1:0]     old_y;
  logic signed [SW-1:0]     old_s;
  logic signed [SUM_W-1:0]  sel_sum;
  logic [SUM_W-1:0]         sel_mag;
  logic [REM_W-1:0]         rem_sh;
  logic                     div_ge;
  logic [REM_W-1:0]         rem_next;
  logic [SUM_W-1:0]         quo_next;
  logic [SUM_W-1:0]         quo_signed;
  logic                     out_free;

  // Effective window length: zero acts as one, saturate at the capacity.
  assign wl_ext = LW'(window_length);
  always_comb begin
    priority if (window_length == '0) begin
      eff_len = LW'(1);
    end else if (wl_ext > LW'(WINDOW_CAPACITY)) begin
      eff_len = LW'(WINDOW_CAPACITY);
    end else begin
      eff_len = wl_ext;
    end
  end

  // A shortened window may leave the write slot beyond its end.
  assign start_slot     = (LW'(write_slot) >= eff_len) ? '0 : write_slot;
  assign slot_inc       = LW'(cur_slot) + LW'(1);
  assign slot_wrap_next = (slot_inc >= eff_len) ? '0 : slot_inc[SLOT_W-1:0];
  assign window_full    = LW'(fill_count) >= eff_len;

  assign old_x = rd_data[SW-1:0];
  assign old_y = rd_data[2*SW-1:SW];
  assign old_s = rd_data[3*SW-1:2*SW];

  assign cfg_we  = psel && penable && pwrite && pready
                   && (paddr[2] == wsa_pkg::ADDR_WINDOW_LENGTH);
  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == wsa_pkg::ADDR_WINDOW_LENGTH)
                   ? {{(32 - CW){1'b0}}, window_length} : '0;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {{(OUT_W - 3 * SW - CW){1'b0}}, out_s, out_y, out_x, out_count};

  // Divider operand selection and one restoring step on the magnitude.
  always_comb begin
    unique case (comp)
      COMP_X:  sel_sum = sum_x;
      COMP_Y:  sel_sum = sum_y;
      default: sel_sum = sum_speed;
    endcase
  end
  assign sel_mag    = sel_sum[SUM_W-1] ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);
  assign rem_sh     = {div_rem[REM_W-2:0], div_quo[SUM_W-1]};
  assign div_ge     = rem_sh >= {1'b0, fill_count};
  assign rem_next   = div_ge ? rem_sh - {1'b0, fill_count} : rem_sh;
  assign quo_next   = {div_quo[SUM_W-2:0], div_ge};
  assign quo_signed = div_neg ? SUM_W'(-quo_next) : quo_next;

  // Sample store, written and read in one clocked block.
  always_ff @(posedge clk) begin
    if (state == ST_UPD) begin
      store[cur_slot] <= {in_s, in_y, in_x};
    end
    rd_data <= store[cur_slot];
  end

  // Control state and window bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      window_length <= wsa_pkg::WINDOW_RESET_LENGTH;
      write_slot    <= '0;
      fill_count    <= '0;
      sum_x         <= '0;
      sum_y         <= '0;
      sum_speed     <= '0;
      comp          <= COMP_X;
      step          <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        window_length <= pwdata[CW-1:0];
        write_slot    <= '0;
        fill_count    <= '0;
        sum_x         <= '0;
        sum_y         <= '0;
        sum_speed     <= '0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (window_full) begin
            sum_x     <= sum_x + SUM_W'(in_x) - SUM_W'(old_x);
            sum_y     <= sum_y + SUM_W'(in_y) - SUM_W'(old_y);
            sum_speed <= sum_speed + SUM_W'(in_s) - SUM_W'(old_s);
          end else begin
            fill_count <= fill_count + CW'(1);
            sum_x      <= sum_x + SUM_W'(in_x);
            sum_y      <= sum_y + SUM_W'(in_y);
            sum_speed  <= sum_speed + SUM_W'(in_s);
          end
          write_slot <= slot_wrap_next;
          comp       <= COMP_X;
          state      <= ST_LOAD;
        end
        ST_LOAD: begin
          step  <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          step <= step + STEP_W'(1);
          if (step == STEP_W'(SUM_W - 1)) begin
            if (comp == COMP_SPEED) begin
              state <= ST_DONE;
            end else begin
              comp  <= comp + 2'd1;
              state <= ST_LOAD;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      in_x     <= s_tdata[SW-1:0];
      in_y     <= s_tdata[2*SW-1:SW];
      in_s     <= s_tdata[3*SW-1:2*SW];
      cur_slot <= start_slot;
    end
    if (state == ST_LOAD) begin
      div_neg <= sel_sum[SUM_W-1];
      div_quo <= sel_mag;
      div_rem <= '0;
    end
    if (state == ST_DIV) begin
      div_rem <= rem_next;
      div_quo <= quo_next;
      if (step == STEP_W'(SUM_W - 1)) begin
        unique case (comp)
          COMP_X:  avg_x <= quo_signed[SW-1:0];
          COMP_Y:  avg_y <= quo_signed[SW-1:0];
          default: avg_s <= quo_signed[SW-1:0];
        endcase
      end
    end
    if (state == ST_DONE && out_free) begin
      out_count <= fill_count;
      out_x     <= avg_x;
      out_y     <= avg_y;
      out_s     <= avg_s;
    end
  end

  // The window never holds more samples than its effective length.
  a_fill_in_window: assert property (@(posedge clk) disable iff (rst)
    LW'(fill_count) <= eff_len)
    else $error("fill count exceeds window length");

  // The next write position always lies inside the current window.
  a_slot_in_window: assert property (@(posedge clk) disable iff (rst)
    LW'(write_slot) < eff_len)
    else $error("write slot outside window");

  // A result only appears after the divider has finished all three averages.
  a_result_after_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_DONE)
    else $error("result raised outside completion state");

  // The divisor is never zero while the divider runs.
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> fill_count != '0)
    else $error("divider running with zero count");

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for windowed_sample_average_top.
// Depends on wsa_pkg and the block's RTL; it drives the stream and APB ports and
// predicts every average word from its own model of the ring and running sums.
`timescale 1ns / 100ps

module testbench;

  localparam int SW          = wsa_pkg::SAMPLE_WIDTH_DEF;
  localparam int CAPACITY    = wsa_pkg::WINDOW_CAPACITY_DEF;
  localparam int COUNT_W     = wsa_pkg::COUNT_W;
  localparam int IN_W        = 48;
  localparam int OUT_W       = 56;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 72;
  localparam logic [2:0] WINDOW_LENGTH_ADDR = {wsa_pkg::ADDR_WINDOW_LENGTH, 2'b00};

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [SW-1:0]      avg_x;
    logic [SW-1:0]      avg_y;
    logic [SW-1:0]      avg_speed;
  } average_word_t;

  // Ring of recent samples with running sums; queues the average word that
  // each accepted sample must produce and compares the words that come out.
  class window_tracker;
    logic signed [SW-1:0] ring_x[CAPACITY];
    logic signed [SW-1:0] ring_y[CAPACITY];
    logic signed [SW-1:0] ring_s[CAPACITY];
    logic [COUNT_W-1:0]   length_reg;
    int                   next_slot;
    int                   held;
    int                   sum_x;
    int                   sum_y;
    int                   sum_s;
    average_word_t        pending_averages[$];
    int                   errors;
    int                   checked;

    function new();
      errors     = 0;
      checked    = 0;
      length_reg = wsa_pkg::WINDOW_RESET_LENGTH;
      clear();
    endfunction

    function void clear();
      next_slot = 0;
      held      = 0;
      sum_x     = 0;
      sum_y     = 0;
      sum_s     = 0;
      for (int i = 0; i < CAPACITY; i++) begin
        ring_x[i] = '0;
        ring_y[i] = '0;
        ring_s[i] = '0;
      end
    endfunction

    function void set_length(logic [COUNT_W-1:0] value);
      length_reg = value;
      clear();
    endfunction

    function int active_length();
      if (length_reg == 0) return 1;
      if (length_reg > CAPACITY) return CAPACITY;
      return int'(length_reg);
    endfunction

    function int pending();
      return pending_averages.size();
    endfunction

    task flag_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d, expected %0d (at %0t)", what, got, want, $realtime);
      errors++;
    endtask

    function void note_sample(logic signed [SW-1:0] x, logic signed [SW-1:0] y,
                              logic signed [SW-1:0] s);
      int            len;
      int            slot;
      average_word_t word;
      len  = active_length();
      slot = next_slot;
      if (slot >= len) slot = 0;
      if (held < len) begin
        held++;
      end else begin
        sum_x -= int'(ring_x[slot]);
        sum_y -= int'(ring_y[slot]);
        sum_s -= int'(ring_s[slot]);
      end
      ring_x[slot] = x;
      ring_y[slot] = y;
      ring_s[slot] = s;
      sum_x += int'(x);
      sum_y += int'(y);
      sum_s += int'(s);
      slot++;
      if (slot >= len) slot = 0;
      next_slot = slot;
      // Integer division in SystemVerilog truncates toward zero.
      word.count     = held[COUNT_W-1:0];
      word.avg_x     = SW'(sum_x / held);
      word.avg_y     = SW'(sum_y / held);
      word.avg_speed = SW'(sum_s / held);
      pending_averages.push_back(word);
    endfunction

    task check_average(logic [OUT_W-1:0] data);
      average_word_t want;
      average_word_t got;
      got.count     = data[4:0];
      got.avg_x     = data[20:5];
      got.avg_y     = data[36:21];
      got.avg_speed = data[52:37];
      if (pending_averages.size() == 0) begin
        flag_mismatch("unexpected output word, count", int'(got.count), 0);
      end else begin
        want = pending_averages.pop_front();
        checked++;
        if (got.count != want.count)
          flag_mismatch("sample_count", int'(got.count), int'(want.count));
        if (got.avg_x != want.avg_x)
          flag_mismatch("avg_x", int'($signed(got.avg_x)), int'($signed(want.avg_x)));
        if (got.avg_y != want.avg_y)
          flag_mismatch("avg_y", int'($signed(got.avg_y)), int'($signed(want.avg_y)));
        if (got.avg_speed != want.avg_speed)
          flag_mismatch("avg_speed", int'($signed(got.avg_speed)),
                        int'($signed(want.avg_speed)));
      end
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [2:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  window_tracker tracker = new();
  bit            idling_on = 1'b1;
  int            ready_hold = 0;
  int            cycle_count = 0;
  int            samples_sent = 0;
  int            settings_used = 0;

  windowed_sample_average_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d words outstanding.",
               cycle_count, tracker.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_average(m_tdata);
  end

  // Random receiver back-pressure in bursts while idling_on is set.
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      m_tready   <= 1'b0;
      ready_hold = $urandom_range(0, 7);
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic logic [SW-1:0] pick_field();
    unique case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return SW'($urandom);
    endcase
  endfunction

  task automatic send_sample(logic [SW-1:0] x, logic [SW-1:0] y, logic [SW-1:0] s);
    int gap;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {s, y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.note_sample(x, y, s);
    samples_sent++;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= IN_W'({$urandom, $urandom});
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic release_valid();
    @(negedge clk);
    s_tvalid <= 1'b0;
    s_tdata  <= IN_W'({$urandom, $urandom});
  endtask

  task automatic wait_drain();
    while (tracker.pending() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_window_length(logic [COUNT_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WINDOW_LENGTH_ADDR;
    pwdata  <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracker.set_length(value);
    settings_used++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic read_window_length(logic [COUNT_W-1:0] want);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= WINDOW_LENGTH_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata != 32'(want))
      tracker.flag_mismatch("window_length readback", int'(prdata), int'(want));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(logic [COUNT_W-1:0] len, int count, bit drain_midway);
    write_window_length(len);
    read_window_length(len);
    for (int i = 0; i < count; i++) begin
      send_sample(pick_field(), pick_field(), pick_field());
      // Hold the sender off until the block has returned everything.
      if (drain_midway && i == count / 2) begin
        release_valid();
        wait_drain();
      end
    end
    release_valid();
    wait_drain();
  endtask

  initial begin
    logic [COUNT_W-1:0] fixed_lengths[6];
    logic [COUNT_W-1:0] len;
    int                 phase;
    int                 count;
    fixed_lengths = '{5'd16, 5'd1, 5'd17, 5'd2, 5'd31, 5'd0};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset length of ten: saturating values, then a wrap past the oldest entry.
    read_window_length(wsa_pkg::WINDOW_RESET_LENGTH);
    repeat (4) send_sample(16'h7fff, 16'h7fff, 16'h7fff);
    repeat (4) send_sample(16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h0000, 16'hffff, 16'h0001);
    send_sample(16'h8000, 16'h7fff, 16'h0000);
    send_sample(16'h7fff, 16'h8000, 16'hffff);
    send_sample(16'h0001, 16'hffff, 16'h8000);
    send_sample(16'hffff, 16'hffff, 16'hffff);
    release_valid();
    wait_drain();

    // A length of zero behaves as a window of one sample.
    write_window_length(5'd0);
    read_window_length(5'd0);
    send_sample(16'h8000, 16'h7fff, 16'hffff);
    send_sample(16'h7fff, 16'h8000, 16'h0001);
    send_sample(16'hffff, 16'h0000, 16'h8000);
    release_valid();
    wait_drain();

    phase = 0;
    while (samples_sent < 1000) begin
      if (phase < 6) len = fixed_lengths[phase];
      else if ($urandom_range(0, 3) == 0) len = fixed_lengths[$urandom_range(0, 5)];
      else len = COUNT_W'($urandom);
      count = (len == 0 || len > 8) ? $urandom_range(20, 60) : $urandom_range(4, 40);
      idling_on = ($urandom_range(0, 3) != 0);
      run_phase(len, count, phase == 3);
      phase++;
    end

    // Closing stretch at full rate on both sides.
    idling_on = 1'b0;
    run_phase(5'd16, 60, 1'b0);

    $display("Sent %0d samples over %0d window length settings; %0d average words checked.",
             samples_sent, settings_used, tracker.checked);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d words outstanding.", tracker.errors, tracker.pending());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ windowed_sample_average_top.f @@
rtl/wsa_pkg.sv
rtl/windowed_sample_average_top.sv
dv/testbench.sv
